FILE: hdl/euler_to_quaternion_unit_macros.svh
// Assertion macros shared by the checker of the Euler angle to quaternion unit.
`ifndef EULER_TO_QUATERNION_UNIT_MACROS_SVH
`define EULER_TO_QUATERNION_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define E2Q_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("e2q check failed");
// Next-cycle implication checked on every clock edge outside reset.
`define E2Q_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("e2q check failed");
`endif

FILE: hdl/e2q_pkg.sv
// Package of constants, types and tables for the Euler angle to quaternion unit.
package e2q_pkg;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int FRACTION_BITS_DEF = 14;
	localparam int CORDIC_STEPS      = 30;
	localparam int OUT_BITS          = 16;
	localparam int ANGLE_BITS_PORT   = 16;
	localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
	localparam logic        [31:0] QUARTER_TURN = 32'h4000_0000;

	typedef logic signed [33:0] q30_t;

	function automatic logic signed [33:0] atan_turn(input int idx);
		logic [31:0] v;
		begin
			case (idx)
				0:  v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
				3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
				6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
				9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
				12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
				15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
				18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
				21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
				24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
				27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
				default: v = 32'h0;
			endcase
			return $signed({2'b00, v});
		end
	endfunction
endpackage

FILE: hdl/e2q_cordic_step.sv
// One registered CORDIC micro-rotation stage carrying the fold flag along.
module e2q_cordic_step import e2q_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  q30_t x_in,
	input  q30_t y_in,
	input  q30_t z_in,
	input  logic fold_in,
	output q30_t x_s1,
	output q30_t y_s1,
	output q30_t z_s1,
	output logic fold_s1
);
	q30_t dx, dy;
	assign dx = x_in >>> STEP;
	assign dy = y_in >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[33]) begin
				x_s1 <= x_in - dy;
				y_s1 <= y_in + dx;
				z_s1 <= z_in - atan_turn(STEP);
			end else begin
				x_s1 <= x_in + dy;
				y_s1 <= y_in - dx;
				z_s1 <= z_in + atan_turn(STEP);
			end
			fold_s1 <= fold_in;
		end
	end
endmodule

FILE: hdl/e2q_half_cos_sin.sv
// Pipelined CORDIC giving cosine and sine of half a binary angle in Q30.
module e2q_half_cos_sin import e2q_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic [CORDIC_STEPS:0] en,
	input  logic [ANGLE_BITS-1:0] angle,
	output q30_t                  cos_q,
	output q30_t                  sin_q
);
	q30_t xs [CORDIC_STEPS+1];
	q30_t ys [CORDIC_STEPS+1];
	q30_t zs [CORDIC_STEPS+1];
	logic fs [CORDIC_STEPS+1];
	logic [31:0] t;

	assign t = 32'({angle, (31 - ANGLE_BITS)'(0)});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xs[0] <= CORDIC_GAIN;
			ys[0] <= '0;
			fs[0] <= (t >= QUARTER_TURN);
			zs[0] <= (t >= QUARTER_TURN) ? $signed({2'b00, t - QUARTER_TURN})
			                             : $signed({2'b00, t});
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		e2q_cordic_step #(.STEP(i)) u_step (
			.clk(clk), .en(en[i+1]),
			.x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]), .fold_in(fs[i]),
			.x_s1(xs[i+1]), .y_s1(ys[i+1]), .z_s1(zs[i+1]), .fold_s1(fs[i+1])
		);
	end

	assign cos_q = fs[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : xs[CORDIC_STEPS];
	assign sin_q = fs[CORDIC_STEPS] ? xs[CORDIC_STEPS] : ys[CORDIC_STEPS];
endmodule

FILE: hdl/e2q_products.sv
// Triple-product and sum pipeline forming the four quaternion components.
module e2q_products import e2q_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic       clk,
	input  logic [3:0] en,
	input  q30_t       cr, sr, cp, sp, cy, sy,
	output logic signed [OUT_BITS-1:0] qw, qx, qy, qz
);
	localparam int SH = 60 - FRACTION_BITS;
	typedef logic signed [67:0] p_t;
	// Stage 1: pair products yaw by roll, rounded to Q30; pitch carried.
	q30_t cycr_s1, cysr_s1, sycr_s1, sysr_s1, cp_s1, sp_s1;
	// Stage 2: eight triple products.
	p_t t_s2 [8];
	// Stage 3: four sums.
	p_t sum_s3 [4];
	logic signed [OUT_BITS-1:0] res_s4 [4];

	function automatic q30_t rq(input q30_t a, input q30_t b);
		p_t p;
		begin
			p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
			return 34'(p >>> 30);
		end
	endfunction

	function automatic logic signed [OUT_BITS-1:0] sat(input p_t s);
		p_t q;
		p_t one;
		begin
			one = 68'sd1 <<< FRACTION_BITS;
			q = (s + (68'sd1 <<< (SH - 1))) >>> SH;
			if (q > one) q = one;
			if (q < -one) q = -one;
			return q[OUT_BITS-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cycr_s1 <= rq(cy, cr);
			cysr_s1 <= rq(cy, sr);
			sycr_s1 <= rq(sy, cr);
			sysr_s1 <= rq(sy, sr);
			cp_s1   <= cp;
			sp_s1   <= sp;
		end
		if (en[1]) begin
			t_s2[0] <= 68'(cycr_s1) * 68'(cp_s1);
			t_s2[1] <= 68'(sysr_s1) * 68'(sp_s1);
			t_s2[2] <= 68'(cysr_s1) * 68'(cp_s1);
			t_s2[3] <= 68'(sycr_s1) * 68'(sp_s1);
			t_s2[4] <= 68'(cycr_s1) * 68'(sp_s1);
			t_s2[5] <= 68'(sysr_s1) * 68'(cp_s1);
			t_s2[6] <= 68'(sycr_s1) * 68'(cp_s1);
			t_s2[7] <= 68'(cysr_s1) * 68'(sp_s1);
		end
		if (en[2]) begin
			sum_s3[0] <= t_s2[0] + t_s2[1];
			sum_s3[1] <= t_s2[2] - t_s2[3];
			sum_s3[2] <= t_s2[4] + t_s2[5];
			sum_s3[3] <= t_s2[6] - t_s2[7];
		end
		if (en[3]) begin
			for (int k = 0; k < 4; k++) res_s4[k] <= sat(sum_s3[k]);
		end
	end

	assign qw = res_s4[0];
	assign qx = res_s4[1];
	assign qy = res_s4[2];
	assign qz = res_s4[3];
endmodule

FILE: hdl/euler_to_quaternion_unit.sv
// Top level of the Euler angle to quaternion unit.
// Converts a roll, pitch, yaw triple of binary angles (a full turn is
// 2^ANGLE_BITS) into a unit quaternion in the Z-Y-X convention. Each half
// angle goes through a 30-stage pipelined CORDIC, three of them side by side,
// and a four-stage product tree then forms the pair products, the triple
// products, the sums and the rounded, saturated Q2.14 results. A new
// transaction may be accepted in every cycle unless the pipeline is stalled;
// it passes the 31 CORDIC registers and then the four product stages. Every
// stage carries a valid bit. Stall propagates backwards only through full
// stages, so bubbles close up while the output is stalled and nothing is
// lost or repeated. Nothing is kept from one transaction to the next.
module euler_to_quaternion_unit import e2q_pkg::*; #(
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [ANGLE_BITS_PORT-1:0] roll_angle,
	input  logic [ANGLE_BITS_PORT-1:0] pitch_angle,
	input  logic [ANGLE_BITS_PORT-1:0] yaw_angle,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [OUT_BITS-1:0] quat_w,
	output logic signed [OUT_BITS-1:0] quat_x,
	output logic signed [OUT_BITS-1:0] quat_y,
	output logic signed [OUT_BITS-1:0] quat_z
);
	localparam int DEPTH = CORDIC_STEPS + 5;

	// One valid bit per pipeline register stage.
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] adv;
	q30_t cr, sr, cp, sp, cy, sy;

	// A stage may load when it is empty or when its content moves on.
	always_comb begin
		adv[DEPTH-1] = !vld_q[DEPTH-1] || !out_stall;
		for (int k = DEPTH - 2; k >= 0; k--) adv[k] = !vld_q[k] || adv[k+1];
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < DEPTH; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// The angle ports are resized to ANGLE_BITS: upper bits are dropped or
	// zeros are added, so a wider angle simply sees the port value.
	e2q_half_cos_sin #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
		.clk(clk), .en(adv[CORDIC_STEPS:0]),
		.angle(ANGLE_BITS'(roll_angle)), .cos_q(cr), .sin_q(sr)
	);
	e2q_half_cos_sin #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
		.clk(clk), .en(adv[CORDIC_STEPS:0]),
		.angle(ANGLE_BITS'(pitch_angle)), .cos_q(cp), .sin_q(sp)
	);
	e2q_half_cos_sin #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
		.clk(clk), .en(adv[CORDIC_STEPS:0]),
		.angle(ANGLE_BITS'(yaw_angle)), .cos_q(cy), .sin_q(sy)
	);

	e2q_products #(.FRACTION_BITS(FRACTION_BITS)) u_prod (
		.clk(clk), .en(adv[DEPTH-1:CORDIC_STEPS+1]),
		.cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
		.qw(quat_w), .qx(quat_x), .qy(quat_y), .qz(quat_z)
	);
endmodule

FILE: hdl/e2q_checker.sv
// Port-level checker for the Euler angle to quaternion unit, with its bind.
`include "euler_to_quaternion_unit_macros.svh"
module e2q_checker import e2q_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [OUT_BITS-1:0] quat_w,
	input logic signed [OUT_BITS-1:0] quat_x
);
	// The w and x components never leave plus or minus one.
	`E2Q_ASSERT_IMP(a_w_range, out_valid, (quat_w <= 16'sd16384) && (quat_w >= -16'sd16384))
	`E2Q_ASSERT_IMP(a_x_range, out_valid, (quat_x <= 16'sd16384) && (quat_x >= -16'sd16384))
	// A stalled result stays.
	`E2Q_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(quat_w))
	// The input is never stalled while the output side takes data.
	`E2Q_ASSERT_IMP(a_flow, !out_stall, !in_stall)
	// A stalled input transaction is still offered in the next cycle.
	`E2Q_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid)
endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .quat_w(quat_w), .quat_x(quat_x)
);

FILE: test/testbench.sv
// Self-checking testbench for the Euler angle to quaternion unit.
module testbench;
	import e2q_pkg::*;

	typedef struct packed {
		logic [15:0] roll;
		logic [15:0] pitch;
		logic [15:0] yaw;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	// One row of the directed table; the quaternion is typed in only where it is obvious.
	typedef struct {
		angles_t ang;
		bit      known;
		quat_t   q;
	} row_t;

	localparam int N_RANDOM   = 1830;
	localparam int N_DIRECTED = 16;
	localparam int LATENCY    = 35;
	localparam int CYCLE_CAP  = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] roll_angle = '0;
	logic [15:0] pitch_angle = '0;
	logic [15:0] yaw_angle = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

	quat_t expected_quats[$];
	int errors = 0;
	int received = 0;
	int cycles = 0;
	bit long_hold = 1'b0;
	bit feeding_done = 1'b0;

	euler_to_quaternion_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.out_valid(out_valid), .out_stall(out_stall),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
	);

	always #1 clk = ~clk;

	// Arithmetic shift right that floors, as the CORDIC and the rounding require.
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	// Cosine and sine of half the binary angle, in Q30, from a 30-step CORDIC.
	function automatic void half_angle_trig(logic [15:0] a, output longint c,
		output longint s);
		longint t, x, y, z, dx, dy;
		bit folded;
		t = longint'(a) << 15;
		folded = 1'b0;
		if (t >= longint'(QUARTER_TURN)) begin
			t -= longint'(QUARTER_TURN);
			folded = 1'b1;
		end
		x = 652032874;
		y = 0;
		z = t;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_turn(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_turn(i));
			end
		end
		if (folded) begin
			c = -y; s = x;
		end else begin
			c = x; s = y;
		end
	endfunction

	function automatic longint product3(longint a, longint b, longint c);
		return floor_shr(a * b + (longint'(1) << 29), 30) * c;
	endfunction

	// Rounds a Q60 sum to Q2.14, ties upwards, and clamps to plus or minus one.
	function automatic logic signed [15:0] to_q14(longint sum);
		longint q;
		q = floor_shr(sum + (longint'(1) << 45), 46);
		if (q > 16384) q = 16384;
		if (q < -16384) q = -16384;
		return q[15:0];
	endfunction

	function automatic quat_t zyx_quaternion(angles_t a);
		longint cr, sr, cp, sp, cy, sy;
		quat_t q;
		half_angle_trig(a.roll, cr, sr);
		half_angle_trig(a.pitch, cp, sp);
		half_angle_trig(a.yaw, cy, sy);
		q.w = to_q14(product3(cy, cr, cp) + product3(sy, sr, sp));
		q.x = to_q14(product3(cy, sr, cp) - product3(sy, cr, sp));
		q.y = to_q14(product3(cy, cr, sp) + product3(sy, sr, cp));
		q.z = to_q14(product3(sy, cr, cp) - product3(cy, sr, sp));
		return q;
	endfunction

	// Appends an expectation at the tail of the queue.
	function automatic void enqueue_expected(quat_t q);
		expected_quats = {expected_quats, q};
	endfunction

	// Offers one transaction after a random gap and holds it until accepted.
	// Valid stays high on return so that a following transaction can come
	// without a gap; the caller drops it when nothing more follows.
	task automatic send_angles(angles_t a, bit has_q, quat_t q);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
		if ($urandom_range(0, 1)) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		roll_angle <= a.roll;
		pitch_angle <= a.pitch;
		yaw_angle <= a.yaw;
		do @(posedge clk); while (in_stall);
		enqueue_expected(has_q ? q : zyx_quaternion(a));
	endtask

	function automatic angles_t random_angles();
		angles_t a;
		case ($urandom_range(0, 5))
			0: a = {16'(($urandom_range(0, 7)) << 13), 16'(($urandom_range(0, 7)) << 13),
				16'(($urandom_range(0, 7)) << 13)};
			1: a = {16'($urandom_range(16380, 16388)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(65530, 65535))};
			default: a = {16'($urandom), 16'($urandom), 16'($urandom)};
		endcase
		return a;
	endfunction

	// Receiver: random stalls, with one long hold-off while the sender keeps going.
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (150) @(posedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (feeding_done || $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b0;
			end else begin
				wait_n = $urandom_range(0, 18);
				if (wait_n != 0) begin
					out_stall <= 1'b1;
					repeat (wait_n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n && out_valid && !out_stall) begin
			received++;
			if (expected_quats.size() == 0) begin
				errors++;
				$display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d",
					$time, quat_w, quat_x, quat_y, quat_z);
			end else begin
				exp_q = expected_quats.pop_front();
				if (quat_w !== exp_q.w) begin
					errors++;
					$display("%0t: w expected %0d got %0d", $time, exp_q.w, quat_w);
				end
				if (quat_x !== exp_q.x) begin
					errors++;
					$display("%0t: x expected %0d got %0d", $time, exp_q.x, quat_x);
				end
				if (quat_y !== exp_q.y) begin
					errors++;
					$display("%0t: y expected %0d got %0d", $time, exp_q.y, quat_y);
				end
				if (quat_z !== exp_q.z) begin
					errors++;
					$display("%0t: z expected %0d got %0d", $time, exp_q.z, quat_z);
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("euler_to_quaternion_unit: mismatch");
			$finish;
		end
	end

	initial begin
		row_t dir_rows[N_DIRECTED];
		row_t r;
		quat_t none;
		none = '0;
		// Zero angles give the identity; a half turn of roll, pitch or yaw alone gives a
		// pure axis quaternion.
		dir_rows[0]  = '{'{16'h0000, 16'h0000, 16'h0000}, 1, '{16384, 0, 0, 0}};
		dir_rows[1]  = '{'{16'h8000, 16'h0000, 16'h0000}, 1, '{0, 16384, 0, 0}};
		dir_rows[2]  = '{'{16'h0000, 16'h8000, 16'h0000}, 1, '{0, 0, 16384, 0}};
		dir_rows[3]  = '{'{16'h0000, 16'h0000, 16'h8000}, 1, '{0, 0, 0, 16384}};
		// Everything else comes from the predictor: extremes, quadrant fold edges,
		// components near plus or minus one where clamping bites.
		dir_rows[4]  = '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, none};
		dir_rows[5]  = '{'{16'hFFFF, 16'h0000, 16'h0000}, 0, none};
		dir_rows[6]  = '{'{16'h0000, 16'hFFFF, 16'h0000}, 0, none};
		dir_rows[7]  = '{'{16'h0000, 16'h0000, 16'hFFFF}, 0, none};
		dir_rows[8]  = '{'{16'h7FFF, 16'h8001, 16'h7FFF}, 0, none};
		dir_rows[9]  = '{'{16'h4000, 16'h4000, 16'h4000}, 0, none};
		dir_rows[10] = '{'{16'hC000, 16'hC000, 16'hC000}, 0, none};
		dir_rows[11] = '{'{16'h0001, 16'h0001, 16'h0001}, 0, none};
		dir_rows[12] = '{'{16'h5555, 16'hAAAA, 16'h5555}, 0, none};
		dir_rows[13] = '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 0, none};
		dir_rows[14] = '{'{16'h2000, 16'hE000, 16'h6000}, 0, none};
		dir_rows[15] = '{'{16'h8000, 16'h8000, 16'h8000}, 0, none};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			send_angles(r.ang, r.known, r.q);
		end
		in_valid <= 1'b0;

		// Sender pause until the pipeline has drained completely.
		while (expected_quats.size() != 0) @(posedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 600) long_hold = 1'b1;
			send_angles(random_angles(), 0, none);
		end
		in_valid <= 1'b0;
		// The receiver stops stalling so that the remaining results drain.
		feeding_done = 1'b1;
		while (expected_quats.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Covered %0d results: directed axes and extremes, then random angle", received);
		$display("triples under random gaps, stalls and one long output hold-off.");
		if (errors == 0 && expected_quats.size() == 0) begin
			$display("euler_to_quaternion_unit: match");
		end else begin
			$display("euler_to_quaternion_unit: mismatch");
		end
		$finish;
	end
endmodule
